[hw/rtl/assert_macros.svh]
// assertion macros used by the subdivider core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk outside reset
`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/stsub_pkg.sv]
// types and constants of the sphere triangle subdivider
`default_nettype none
package stsub_pkg;
	localparam int COORD_W    = 24;
	localparam int RAD_W      = 23;
	localparam int SUM_W      = COORD_W + 1;
	localparam int MAG_W      = SUM_W;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int SSUM_W     = SQ_W;
	localparam int PROD_W     = MAG_W + RAD_W;
	localparam int SQRT_EXTRA = 6;
	localparam int RAD_IN_W   = SSUM_W + 2 * SQRT_EXTRA;
	localparam int ROOT_W     = RAD_IN_W / 2;
	localparam int REM_W      = ROOT_W + 3;
	localparam int QUO_W      = COORD_W;
	localparam int NUM_W      = ROOT_W + QUO_W;
	// s1..s3, root stages, numerator, divide stages, saturation
	localparam int MID_LAT    = 3 + ROOT_W + 1 + QUO_W + 1;

	localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(65536);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef coord_t [2:0] vec3_t;

	typedef struct packed {
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t c_x;
		coord_t c_y;
		coord_t c_z;
	} in_word_t;

	typedef struct packed {
		coord_t first_x;
		coord_t first_y;
		coord_t first_z;
		coord_t second_x;
		coord_t second_y;
		coord_t second_z;
		coord_t third_x;
		coord_t third_y;
		coord_t third_z;
		logic   last_of_four;
		logic   degenerate;
	} out_word_t;

	typedef enum logic [1:0] {
		BEAT_FIRST,
		BEAT_SECOND,
		BEAT_THIRD,
		BEAT_LAST
	} beat_t;
endpackage
`default_nettype wire

[hw/rtl/sphere_triangle_subdivider_core.sv]
// top level of the sphere triangle subdivider: midpoint pipelines and result serializer
// an input passes 60 pipeline stages and the serializer register before its first output word
// throughput: one input word per cycle into the pipeline while it is not halted; the sustained
// input rate is limited by the single output channel giving four triangles per input
// the pipeline depth comes from the 31-stage square root and the 24-stage divider
// reset (arst_n low, asynchronous): valid bits and serializer cleared, radius back to 1.0
`default_nettype none
module sphere_triangle_subdivider_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [stsub_pkg::RAD_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  stsub_pkg::in_word_t         in_word,
	output logic                        out_valid,
	input  logic                        out_ready,
	output stsub_pkg::out_word_t        out_word
);
	import stsub_pkg::*;

	`include "assert_macros.svh"

	// radius register
	logic [RAD_W-1:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// whole pipeline moves together; it halts only when its last stage holds a word
	// that the serializer cannot take
	logic en;
	logic end_valid;
	logic sr_free;
	logic load;

	assign en       = !end_valid || sr_free;
	assign in_ready = en;
	assign load     = en && end_valid;

	// valid bits and the untouched vertices ride alongside the midpoint units
	logic     vld_s [MID_LAT];
	in_word_t vtx_s [MID_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MID_LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < MID_LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vtx_s[0] <= in_word;
			for (int k = 1; k < MID_LAT; k++) begin
				vtx_s[k] <= vtx_s[k-1];
			end
		end
	end

	assign end_valid = vld_s[MID_LAT-1];

	// the three edges: m1 on a-b, m2 on b-c, m3 on a-c
	vec3_t pa, pb, pc;
	vec3_t m1, m2, m3;
	logic  z1, z2, z3;

	assign pa = {in_word.a_z, in_word.a_y, in_word.a_x};
	assign pb = {in_word.b_z, in_word.b_y, in_word.b_x};
	assign pc = {in_word.c_z, in_word.c_y, in_word.c_x};

	stsub_mid u_mid_ab (
		.clk    (clk),
		.en     (en),
		.radius (radius_q),
		.p      (pa),
		.q      (pb),
		.m      (m1),
		.zero   (z1)
	);

	stsub_mid u_mid_bc (
		.clk    (clk),
		.en     (en),
		.radius (radius_q),
		.p      (pb),
		.q      (pc),
		.m      (m2),
		.zero   (z2)
	);

	stsub_mid u_mid_ac (
		.clk    (clk),
		.en     (en),
		.radius (radius_q),
		.p      (pa),
		.q      (pc),
		.m      (m3),
		.zero   (z3)
	);

	// serializer: holds one finished input and hands out its four triangles
	logic  sr_valid_q;
	beat_t sr_cnt_q;
	vec3_t sr_a_q, sr_b_q, sr_c_q;
	vec3_t sr_m1_q, sr_m2_q, sr_m3_q;
	logic  sr_degen_q;
	logic  out_fire;
	in_word_t end_vtx;

	assign end_vtx   = vtx_s[MID_LAT-1];
	assign out_fire  = out_valid && out_ready;
	assign sr_free   = !sr_valid_q || (out_ready && sr_cnt_q == BEAT_LAST);
	assign out_valid = sr_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_valid_q <= 1'b0;
			sr_cnt_q   <= BEAT_FIRST;
		end else if (load) begin
			sr_valid_q <= 1'b1;
			sr_cnt_q   <= BEAT_FIRST;
		end else if (out_fire) begin
			if (sr_cnt_q == BEAT_LAST) begin
				sr_valid_q <= 1'b0;
				sr_cnt_q   <= BEAT_FIRST;
			end else begin
				sr_cnt_q <= beat_t'(sr_cnt_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sr_a_q     <= {end_vtx.a_z, end_vtx.a_y, end_vtx.a_x};
			sr_b_q     <= {end_vtx.b_z, end_vtx.b_y, end_vtx.b_x};
			sr_c_q     <= {end_vtx.c_z, end_vtx.c_y, end_vtx.c_x};
			sr_m1_q    <= m1;
			sr_m2_q    <= m2;
			sr_m3_q    <= m3;
			sr_degen_q <= z1 || z2 || z3;
		end
	end

	// triangle order: (a,m1,m3), (m3,m2,c), (m1,b,m2), (m1,m2,m3)
	vec3_t v0, v1, v2;
	logic  last;

	always_comb begin
		case (sr_cnt_q)
			BEAT_FIRST: begin
				v0 = sr_a_q;  v1 = sr_m1_q; v2 = sr_m3_q; last = 1'b0;
			end
			BEAT_SECOND: begin
				v0 = sr_m3_q; v1 = sr_m2_q; v2 = sr_c_q;  last = 1'b0;
			end
			BEAT_THIRD: begin
				v0 = sr_m1_q; v1 = sr_b_q;  v2 = sr_m2_q; last = 1'b0;
			end
			default: begin
				v0 = sr_m1_q; v1 = sr_m2_q; v2 = sr_m3_q; last = 1'b1;
			end
		endcase
	end

	always_comb begin
		out_word.first_x      = v0[0];
		out_word.first_y      = v0[1];
		out_word.first_z      = v0[2];
		out_word.second_x     = v1[0];
		out_word.second_y     = v1[1];
		out_word.second_z     = v1[2];
		out_word.third_x      = v2[0];
		out_word.third_y      = v2[1];
		out_word.third_z      = v2[2];
		out_word.last_of_four = last;
		out_word.degenerate   = sr_degen_q;
	end

	// beat counter rests at the first beat whenever nothing is held
	`ASSERT_AT(a_cnt_idle, !sr_valid_q |-> sr_cnt_q == BEAT_FIRST, "beat count left over")
	// a stalled word at the pipeline end is not dropped
	`ASSERT_AT(a_end_hold, end_valid && !en |=> end_valid, "pipeline end word lost")
	// after the last beat with nothing pending, the serializer empties
	`ASSERT_AT(a_drain, out_fire && sr_cnt_q == BEAT_LAST && !end_valid |=> !sr_valid_q,
		"serializer did not drain")
	// a load never overwrites a word whose beats are not all taken
	`ASSERT_NEVER(a_no_overwrite, load && sr_valid_q && !(out_ready && sr_cnt_q == BEAT_LAST),
		"serializer overwritten")
endmodule
`default_nettype wire

[hw/rtl/stsub_mid.sv]
// pipelined edge midpoint: sum, length by bit-serial root, scale by long division
`default_nettype none
module stsub_mid (
	input  logic                        clk,
	input  logic                        en,
	input  logic [stsub_pkg::RAD_W-1:0] radius,
	input  stsub_pkg::vec3_t            p,
	input  stsub_pkg::vec3_t            q,
	output stsub_pkg::vec3_t            m,
	output logic                        zero
);
	import stsub_pkg::*;

	localparam logic [QUO_W-1:0] POS_LIM = QUO_W'(2 ** (COORD_W - 1) - 1);
	localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(2 ** (COORD_W - 1));

	// s1: endpoint sum, split into magnitude and sign
	logic signed [SUM_W-1:0] sum_c [3];
	logic [2:0][MAG_W-1:0]   mag_s1;
	logic [2:0]              neg_s1;
	logic                    zero_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = SUM_W'($signed(p[i])) + SUM_W'($signed(q[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= sum_c[i][SUM_W-1];
				mag_s1[i] <= MAG_W'(sum_c[i][SUM_W-1] ? -sum_c[i] : sum_c[i]);
			end
			zero_s1 <= (sum_c[0] == '0) && (sum_c[1] == '0) && (sum_c[2] == '0);
		end
	end

	// s2: squares and radius products
	logic [2:0][SQ_W-1:0]   sq_s2;
	logic [2:0][PROD_W-1:0] prod_s2;
	logic [2:0]             neg_s2;
	logic                   zero_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i]   <= SQ_W'(mag_s1[i]) * SQ_W'(mag_s1[i]);
				prod_s2[i] <= PROD_W'(mag_s1[i]) * PROD_W'(radius);
			end
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
		end
	end

	// s3: squared length
	logic [SSUM_W-1:0]      ssum_s3;
	logic [2:0][PROD_W-1:0] prod_s3;
	logic [2:0]             neg_s3;
	logic                   zero_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ssum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			prod_s3 <= prod_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
		end
	end

	// root stages: one result bit per stage
	logic [REM_W-1:0]       rt_rem_s  [ROOT_W];
	logic [ROOT_W-1:0]      rt_root_s [ROOT_W];
	logic [SSUM_W-1:0]      rt_ssum_s [ROOT_W];
	logic [2:0][PROD_W-1:0] rt_prod_s [ROOT_W];
	logic [2:0]             rt_neg_s  [ROOT_W];
	logic                   rt_zero_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		logic [REM_W-1:0]       rem_in;
		logic [ROOT_W-1:0]      root_in;
		logic [SSUM_W-1:0]      ssum_in;
		logic [2:0][PROD_W-1:0] prod_in;
		logic [2:0]             neg_in;
		logic                   zero_in;
		logic [RAD_IN_W-1:0]    rad;
		logic [REM_W-1:0]       rem_sh;
		logic [REM_W-1:0]       trial;

		if (k == 0) begin : g_head
			assign rem_in  = '0;
			assign root_in = '0;
			assign ssum_in = ssum_s3;
			assign prod_in = prod_s3;
			assign neg_in  = neg_s3;
			assign zero_in = zero_s3;
		end else begin : g_body
			assign rem_in  = rt_rem_s[k-1];
			assign root_in = rt_root_s[k-1];
			assign ssum_in = rt_ssum_s[k-1];
			assign prod_in = rt_prod_s[k-1];
			assign neg_in  = rt_neg_s[k-1];
			assign zero_in = rt_zero_s[k-1];
		end

		assign rad    = {ssum_in, {(2 * SQRT_EXTRA){1'b0}}};
		assign rem_sh = {rem_in[REM_W-3:0], rad[RAD_IN_W-1-2*k -: 2]};
		assign trial  = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_sh >= trial) begin
					rt_rem_s[k]  <= rem_sh - trial;
					rt_root_s[k] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rt_rem_s[k]  <= rem_sh;
					rt_root_s[k] <= {root_in[ROOT_W-2:0], 1'b0};
				end
				rt_ssum_s[k] <= ssum_in;
				rt_prod_s[k] <= prod_in;
				rt_neg_s[k]  <= neg_in;
				rt_zero_s[k] <= zero_in;
			end
		end
	end

	// numerator with half the divisor added for round to nearest
	logic [2:0][NUM_W-1:0] nm_num_s;
	logic [ROOT_W-1:0]     nm_len_s;
	logic [2:0]            nm_neg_s;
	logic                  nm_zero_s;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nm_num_s[i] <= NUM_W'({rt_prod_s[ROOT_W-1][i], {SQRT_EXTRA{1'b0}}})
					+ NUM_W'(rt_root_s[ROOT_W-1] >> 1);
			end
			nm_len_s  <= rt_root_s[ROOT_W-1];
			nm_neg_s  <= rt_neg_s[ROOT_W-1];
			nm_zero_s <= rt_zero_s[ROOT_W-1];
		end
	end

	// divide stages: one quotient bit per stage on each axis
	logic [2:0][ROOT_W-1:0] dv_rem_s  [QUO_W];
	logic [2:0][QUO_W-1:0]  dv_quo_s  [QUO_W];
	logic [2:0][NUM_W-1:0]  dv_num_s  [QUO_W];
	logic [ROOT_W-1:0]      dv_len_s  [QUO_W];
	logic [2:0]             dv_neg_s  [QUO_W];
	logic                   dv_zero_s [QUO_W];

	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		logic [2:0][ROOT_W-1:0] rem_in;
		logic [2:0][QUO_W-1:0]  quo_in;
		logic [2:0][NUM_W-1:0]  num_in;
		logic [ROOT_W-1:0]      len_in;
		logic [2:0]             neg_in;
		logic                   zero_in;
		logic [ROOT_W:0]        shifted [3];
		logic [2:0]             ge;

		if (j == 0) begin : g_head
			for (genvar i = 0; i < 3; i++) begin : g_ax
				assign rem_in[i] = nm_num_s[i][NUM_W-1:QUO_W];
			end
			assign quo_in  = '0;
			assign num_in  = nm_num_s;
			assign len_in  = nm_len_s;
			assign neg_in  = nm_neg_s;
			assign zero_in = nm_zero_s;
		end else begin : g_body
			assign rem_in  = dv_rem_s[j-1];
			assign quo_in  = dv_quo_s[j-1];
			assign num_in  = dv_num_s[j-1];
			assign len_in  = dv_len_s[j-1];
			assign neg_in  = dv_neg_s[j-1];
			assign zero_in = dv_zero_s[j-1];
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				shifted[i] = {rem_in[i], num_in[i][QUO_W-1-j]};
				ge[i]      = shifted[i] >= {1'b0, len_in};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[j][i] <= ge[i] ? ROOT_W'(shifted[i] - {1'b0, len_in})
						: shifted[i][ROOT_W-1:0];
					dv_quo_s[j][i] <= {quo_in[i][QUO_W-2:0], ge[i]};
				end
				dv_num_s[j]  <= num_in;
				dv_len_s[j]  <= len_in;
				dv_neg_s[j]  <= neg_in;
				dv_zero_s[j] <= zero_in;
			end
		end
	end

	// sign and saturation
	vec3_t m_s;
	logic  zero_s;
	logic [QUO_W-1:0] quo_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quo_c[i] = dv_quo_s[QUO_W-1][i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_zero_s[QUO_W-1]) begin
					m_s[i] <= '0;
				end else if (dv_neg_s[QUO_W-1][i]) begin
					m_s[i] <= COORD_W'(-((quo_c[i] > NEG_LIM) ? NEG_LIM : quo_c[i]));
				end else begin
					m_s[i] <= COORD_W'((quo_c[i] > POS_LIM) ? POS_LIM : quo_c[i]);
				end
			end
			zero_s <= dv_zero_s[QUO_W-1];
		end
	end

	assign m    = m_s;
	assign zero = zero_s;
endmodule
`default_nettype wire
